// File: sv/tpspwm_pkg.sv
// shared types, widths and constants of the three-phase sine pwm modulator
`default_nettype none

package tpspwm_pkg;

    // fraction bits of the direction vector
    localparam int VECTOR_FRAC_BITS = 15;

    // quotient width: magnitude up to one plus one overflow bit
    localparam int QUO_W   = VECTOR_FRAC_BITS + 17;
    // |voltage| * 10000 and |projection|
    localparam int AV10K_W = 29;
    localparam int AP_W    = 32;
    localparam int NUM_W   = AV10K_W + AP_W;
    // bus * 7071
    localparam int DEN_W   = 29;
    localparam int REM_W   = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;
    // signed projection and sin * sqrt(3)/2 widths
    localparam int P_W     = 34;
    localparam int SQS_W   = 33;
    // duty numerator and period product
    localparam int DNUM_W  = QUO_W + 1;
    localparam int PROD_W  = 16 + DNUM_W;

    localparam int NUM_PHASES = 3;

    localparam logic [13:0] RMS_NUM        = 14'd10000;
    localparam logic [12:0] RMS_DEN        = 13'd7071;
    localparam logic [16:0] SQRT3_HALF_Q16 = 17'd56756;
    localparam logic [15:0] PERIOD_RESET   = 16'd4096;

    // magnitude of one in quotient units; as a duty numerator it gives half duty
    localparam logic [QUO_W-1:0] DUTY_ONE = QUO_W'(1) << (QUO_W - 1);

    typedef struct packed {
        logic signed [15:0] voltage_mv;
        logic signed [15:0] dir_cos;
        logic signed [15:0] dir_sin;
        logic        [15:0] bus_mv;
    } req_item_t;

    typedef struct packed {
        logic [15:0] compare_a;
        logic [15:0] compare_b;
        logic [15:0] compare_c;
        logic        clamped;
    } rsp_item_t;

    // per-phase flags that ride along the divider
    typedef struct packed {
        logic neg;
        logic n_zero;
    } phase_tag_t;

endpackage

`default_nettype wire

// File: sv/tpspwm_div.sv
// pipelined restoring divider, one quotient bit per stage, with overflow detect
`default_nettype none

module tpspwm_div
    import tpspwm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    input  wire phase_tag_t       tag_in,
    output logic [QUO_W-1:0]      quot,
    output logic                  ovf,
    output phase_tag_t            tag_out
);

    logic [REM_W-1:0] rem_reg [QUO_W-1];
    logic [DEN_W-1:0] den_reg [QUO_W-1];
    logic [QUO_W-1:0] quo_reg [QUO_W];
    logic             ovf_reg [QUO_W];
    phase_tag_t       tag_reg [QUO_W];

    logic [REM_W-1:0] rem_prev [QUO_W];
    logic [DEN_W-1:0] den_prev [QUO_W];
    logic [QUO_W-1:0] quo_prev [QUO_W];
    logic             ovf_prev [QUO_W];
    phase_tag_t       tag_prev [QUO_W];

    logic [REM_W-1:0] num_ext;

    assign num_ext = REM_W'(num);

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_step
        localparam int B = QUO_W - 1 - k;

        logic [REM_W-1:0] trial;
        logic             fits;

        if (k == 0)
        begin : g_first
            // quotient does not fit when num >= den * 2^QUO_W
            assign rem_prev[k] = num_ext;
            assign den_prev[k] = den;
            assign quo_prev[k] = '0;
            assign ovf_prev[k] = (num_ext >= REM_W'({den, {QUO_W{1'b0}}}));
            assign tag_prev[k] = tag_in;
        end
        else
        begin : g_rest
            assign rem_prev[k] = rem_reg[k-1];
            assign den_prev[k] = den_reg[k-1];
            assign quo_prev[k] = quo_reg[k-1];
            assign ovf_prev[k] = ovf_reg[k-1];
            assign tag_prev[k] = tag_reg[k-1];
        end

        assign trial = REM_W'(den_prev[k]) << B;
        assign fits  = (rem_prev[k] >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[k] <= quo_prev[k] | (QUO_W'(fits) << B);
                ovf_reg[k] <= ovf_prev[k];
                tag_reg[k] <= tag_prev[k];
            end
        end

        if (k < QUO_W - 1)
        begin : g_fwd
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= fits ? rem_prev[k] - trial : rem_prev[k];
                    den_reg[k] <= den_prev[k];
                end
            end
        end
    end

    assign quot    = quo_reg[QUO_W-1];
    assign ovf     = ovf_reg[QUO_W-1];
    assign tag_out = tag_reg[QUO_W-1];

endmodule

`default_nettype wire

// File: sv/three_phase_sine_pwm_modulator_core.sv
// top level of the three-phase sine pwm modulator: pipeline, config register, output skid
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   req     | req_valid/req_ready  | req_item: voltage, direction cos/sin, bus
//   rsp     | rsp_valid/rsp_ready  | rsp_item: three compare values, clamp flag
//   cfg     | cfg_valid/cfg_ready  | cfg_data: pwm period in ticks
//
// one item per cycle sustained while the skid entry is free; the divider resolves one
// quotient bit per stage
// reset clears all valid bits and loads the period with 4096
// rsp_item sits in an output register backed by one skid entry; the pipeline only
// freezes, as a whole, once the skid entry holds an item, so a waiting result does
// not block new items and a stall drops or repeats nothing
`default_nettype none

module three_phase_sine_pwm_modulator_core
    import tpspwm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire req_item_t   req_item,
    output logic             rsp_valid,
    input  wire logic        rsp_ready,
    output rsp_item_t        rsp_item,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    // ---------------------------------------------------------------
    // config register
    // ---------------------------------------------------------------
    logic [15:0] period_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            period_reg <= PERIOD_RESET;
        else if (cfg_valid)
            period_reg <= cfg_data;
    end

    // whole pipeline advances while the skid entry is free
    logic en;
    logic skid_valid_reg;

    assign en        = !skid_valid_reg;
    assign req_ready = en;

    // ---------------------------------------------------------------
    // stage 1: |voltage| * 10000, sin * sqrt(3)/2, bus * 0.7071 denominator
    // ---------------------------------------------------------------
    logic                    s1_valid_reg;
    logic [AV10K_W-1:0]      s1_av10k_reg;
    logic                    s1_vneg_reg;
    logic signed [15:0]      s1_cos_reg;
    logic signed [SQS_W-1:0] s1_sqs_reg;
    logic [DEN_W-1:0]        s1_den_reg;
    logic                    s1_busz_reg;

    logic signed [16:0]      volt_ext;
    logic [15:0]             av_next;
    logic [AV10K_W-1:0]      av10k_next;
    logic signed [SQS_W-1:0] sqs_next;
    logic [DEN_W-1:0]        den_next;

    assign volt_ext   = {req_item.voltage_mv[15], req_item.voltage_mv};
    assign av_next    = req_item.voltage_mv[15] ? 16'(-volt_ext) : 16'(volt_ext);
    assign av10k_next = AV10K_W'(av_next) * AV10K_W'(RMS_NUM);
    assign sqs_next   = SQS_W'(req_item.dir_sin) * $signed(SQS_W'(SQRT3_HALF_Q16));
    assign den_next   = DEN_W'(req_item.bus_mv) * DEN_W'(RMS_DEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_av10k_reg <= av10k_next;
            s1_vneg_reg  <= req_item.voltage_mv[15];
            s1_cos_reg   <= req_item.dir_cos;
            s1_sqs_reg   <= sqs_next;
            s1_den_reg   <= den_next;
            s1_busz_reg  <= (req_item.bus_mv == 16'd0);
        end
    end

    // ---------------------------------------------------------------
    // stage 2: projections on the 0, 120 and 240 degree axes, magnitude and sign
    // ---------------------------------------------------------------
    logic               s2_valid_reg;
    logic [AV10K_W-1:0] s2_av10k_reg;
    logic [AP_W-1:0]    s2_ap_reg  [NUM_PHASES];
    logic               s2_neg_reg [NUM_PHASES];
    logic [DEN_W-1:0]   s2_den_reg;
    logic               s2_busz_reg;

    logic signed [P_W-1:0] cos_ext;
    logic signed [P_W-1:0] proj     [NUM_PHASES];
    logic [AP_W-1:0]       ap_next  [NUM_PHASES];
    logic                  neg_next [NUM_PHASES];

    assign cos_ext = P_W'(s1_cos_reg);

    always_comb
    begin
        // projections in units of 2^-(frac + 16)
        proj[0] = cos_ext <<< 16;
        proj[1] = -(cos_ext <<< 15) + P_W'(s1_sqs_reg);
        proj[2] = -(cos_ext <<< 15) - P_W'(s1_sqs_reg);
        for (int i = 0; i < NUM_PHASES; i++)
        begin
            ap_next[i]  = proj[i][P_W-1] ? AP_W'(-proj[i]) : AP_W'(proj[i]);
            neg_next[i] = proj[i][P_W-1] ^ s1_vneg_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_av10k_reg <= s1_av10k_reg;
            s2_den_reg   <= s1_den_reg;
            s2_busz_reg  <= s1_busz_reg;
            for (int i = 0; i < NUM_PHASES; i++)
            begin
                s2_ap_reg[i]  <= ap_next[i];
                s2_neg_reg[i] <= neg_next[i];
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 3: dividend = |voltage| * 10000 * |projection|
    // ---------------------------------------------------------------
    logic             s3_valid_reg;
    logic [NUM_W-1:0] s3_n_reg   [NUM_PHASES];
    logic             s3_neg_reg [NUM_PHASES];
    logic [DEN_W-1:0] s3_den_reg;
    logic             s3_busz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (en)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_den_reg  <= s2_den_reg;
            s3_busz_reg <= s2_busz_reg;
            for (int i = 0; i < NUM_PHASES; i++)
            begin
                s3_n_reg[i]   <= NUM_W'(s2_av10k_reg) * NUM_W'(s2_ap_reg[i]);
                s3_neg_reg[i] <= s2_neg_reg[i];
            end
        end
    end

    // ---------------------------------------------------------------
    // divider lanes, one per phase; valid and bus-zero ride a line alongside
    // ---------------------------------------------------------------
    logic [QUO_W-1:0] dv_quot [NUM_PHASES];
    logic             dv_ovf  [NUM_PHASES];
    phase_tag_t       dv_tag  [NUM_PHASES];

    for (genvar p = 0; p < NUM_PHASES; p++)
    begin : g_lane
        phase_tag_t lane_tag;

        assign lane_tag.neg    = s3_neg_reg[p];
        assign lane_tag.n_zero = (s3_n_reg[p] == '0);

        tpspwm_div u_div (
            .clk     (clk),
            .en      (en),
            .num     (s3_n_reg[p]),
            .den     (s3_den_reg),
            .tag_in  (lane_tag),
            .quot    (dv_quot[p]),
            .ovf     (dv_ovf[p]),
            .tag_out (dv_tag[p])
        );
    end

    logic dv_valid_reg [QUO_W];
    logic dv_busz_reg  [QUO_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QUO_W; i++)
                dv_valid_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            dv_valid_reg[0] <= s3_valid_reg;
            for (int i = 1; i < QUO_W; i++)
                dv_valid_reg[i] <= dv_valid_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_busz_reg[0] <= s3_busz_reg;
            for (int i = 1; i < QUO_W; i++)
                dv_busz_reg[i] <= dv_busz_reg[i-1];
        end
    end

    // ---------------------------------------------------------------
    // stage f1: range check, duty numerator one +/- magnitude
    // ---------------------------------------------------------------
    logic              f1_valid_reg;
    logic [DNUM_W-1:0] f1_dnum_reg [NUM_PHASES];
    logic              f1_sat_reg  [NUM_PHASES];
    logic              f1_hi_reg   [NUM_PHASES];
    logic              f1_flag_reg;

    logic [DNUM_W-1:0] dnum_next [NUM_PHASES];
    logic              sat_next  [NUM_PHASES];
    logic              hi_next   [NUM_PHASES];
    logic              over      [NUM_PHASES];
    logic              flag_next;

    always_comb
    begin
        flag_next = dv_busz_reg[QUO_W-1];
        for (int i = 0; i < NUM_PHASES; i++)
        begin
            over[i]      = dv_ovf[i] || (dv_quot[i] > DUTY_ONE);
            flag_next    = flag_next | over[i];
            dnum_next[i] = DNUM_W'(DUTY_ONE);
            sat_next[i]  = 1'b0;
            hi_next[i]   = !dv_tag[i].neg;
            if (dv_tag[i].n_zero)
            begin
                // zero voltage or zero projection: half duty, also on a dead bus
                dnum_next[i] = DNUM_W'(DUTY_ONE);
            end
            else if (over[i])
            begin
                sat_next[i] = 1'b1;
            end
            else if (dv_tag[i].neg)
            begin
                dnum_next[i] = DNUM_W'(DUTY_ONE) - DNUM_W'(dv_quot[i]);
            end
            else
            begin
                dnum_next[i] = DNUM_W'(DUTY_ONE) + DNUM_W'(dv_quot[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f1_valid_reg <= 1'b0;
        else if (en)
            f1_valid_reg <= dv_valid_reg[QUO_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_flag_reg <= flag_next;
            for (int i = 0; i < NUM_PHASES; i++)
            begin
                f1_dnum_reg[i] <= dnum_next[i];
                f1_sat_reg[i]  <= sat_next[i];
                f1_hi_reg[i]   <= hi_next[i];
            end
        end
    end

    // ---------------------------------------------------------------
    // stage f2: compare = period * duty, truncated
    // ---------------------------------------------------------------
    logic        f2_valid_reg;
    rsp_item_t   f2_item_reg;

    logic [PROD_W-1:0] prod [NUM_PHASES];
    logic [15:0]       cmp_next [NUM_PHASES];
    rsp_item_t         f2_item_next;

    always_comb
    begin
        for (int i = 0; i < NUM_PHASES; i++)
        begin
            prod[i] = PROD_W'(period_reg) * PROD_W'(f1_dnum_reg[i]);
            if (f1_sat_reg[i])
                cmp_next[i] = f1_hi_reg[i] ? period_reg : 16'd0;
            else
                cmp_next[i] = prod[i][QUO_W +: 16];
        end
        f2_item_next.compare_a = cmp_next[0];
        f2_item_next.compare_b = cmp_next[1];
        f2_item_next.compare_c = cmp_next[2];
        f2_item_next.clamped   = f1_flag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f2_valid_reg <= 1'b0;
        else if (en)
            f2_valid_reg <= f1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            f2_item_reg <= f2_item_next;
    end

    // ---------------------------------------------------------------
    // output register with one skid entry
    // ---------------------------------------------------------------
    logic      rsp_valid_reg;
    rsp_item_t rsp_item_reg;
    rsp_item_t skid_item_reg;

    logic push;
    logic rsp_valid_next;
    logic skid_valid_next;
    logic rsp_load;
    logic rsp_from_skid;
    logic skid_load;

    assign push = f2_valid_reg & en;

    always_comb
    begin
        rsp_valid_next  = rsp_valid_reg;
        skid_valid_next = skid_valid_reg;
        rsp_load        = 1'b0;
        rsp_from_skid   = 1'b0;
        skid_load       = 1'b0;
        if (!rsp_valid_reg || rsp_ready)
        begin
            rsp_load = 1'b1;
            if (skid_valid_reg)
            begin
                rsp_from_skid   = 1'b1;
                rsp_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                rsp_valid_next = push;
            end
        end
        else if (push)
        begin
            // result waiting downstream: park the new item
            skid_load       = 1'b1;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg  <= rsp_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
            rsp_item_reg <= rsp_from_skid ? skid_item_reg : f2_item_reg;
        if (skid_load)
            skid_item_reg <= f2_item_reg;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

endmodule

`default_nettype wire
